/* src/pcte_pkg.sv */
// ----------------------------------------------------------------------------
// pcte_pkg
// Shared types and constants for the prefix code text encoder.
// ----------------------------------------------------------------------------
package pcte_pkg;

    localparam int CODE_W  = 12;   // longest code word (escape + raw byte)
    localparam int LEN_W   = 4;    // holds code lengths up to 12
    localparam int SYM_W   = 6;    // bits per output symbol
    localparam int CHAR_W  = 7;    // ASCII character
    localparam int PEND_W  = 5;    // at most five bits left over
    localparam int CNT_W   = 3;    // pending count 0..5
    localparam int MAX_OUT = 4;    // characters one item can produce
    localparam int NOUT_W  = 3;    // holds 0..4

    // readable form of the all-zero symbol
    localparam logic [CHAR_W-1:0] CHAR_ZERO_SYM = 7'h61;

    typedef struct packed {
        logic [CODE_W-1:0] bits;   // right aligned
        logic [LEN_W-1:0]  len;
    } t_code;

    typedef struct packed {
        logic [MAX_OUT-1:0][CHAR_W-1:0] chars;   // chars[0] goes out first
        logic [NOUT_W-1:0]              n;
        logic                           fin;
        logic [PEND_W-1:0]              nxt_bits;
        logic [CNT_W-1:0]               nxt_cnt;
        logic                           nxt_odd;
    } t_pack_res;

endpackage

/* src/prefix_code_text_encoder_core.sv */
// ----------------------------------------------------------------------------
// prefix_code_text_encoder_core
// Encodes text bytes with a fixed prefix code and emits the bit stream as
// readable 6-bit-symbol characters, padded to an even count per string.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  input    | in        | i_valid / o_stall    | i_text_byte, i_final_byte
//  output   | out       | o_valid / i_stall    | o_code_char, o_final_char
//
//  Flow: an accepted item waits in the input register, then is
//    encoded in one pass into a batch of 0..4 characters. The batch drains
//    one character per cycle while i_stall is low. Items with no
//    characters pass at one per cycle while the batch is empty or its
//    last character leaves.
//  Reset: synchronous, active low; pending bits, symbol parity and both
//    item registers clear.
//  Stalls: the input register takes one more item while the batch waits
//    on i_stall; o_stall rises only when both stages are full.
//
module prefix_code_text_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_code_char,
    output logic       o_final_char
);
    import pcte_pkg::*;

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_fin;

    // coder state between bytes of one string
    logic [PEND_W-1:0] r_pend_bits;
    logic [CNT_W-1:0]  r_pend_cnt;
    logic              r_odd;

    // result batch
    logic [MAX_OUT-1:0][CHAR_W-1:0] r_chars;
    logic [NOUT_W-1:0] r_cnt;
    logic [1:0]        r_idx;
    logic              r_fin;

    t_code      w_code;
    t_pack_res  w_res;
    logic       w_take_out;
    logic       w_last;
    logic       w_batch_free;
    logic       w_enc_fire;
    logic       w_take_in;

    pcte_code u_code (
        .i_byte (r_in_byte),
        .o_code (w_code)
    );

    pcte_pack u_pack (
        .i_code      (w_code),
        .i_pend_bits (r_pend_bits),
        .i_pend_cnt  (r_pend_cnt),
        .i_odd       (r_odd),
        .i_fin       (r_in_fin),
        .o_res       (w_res)
    );

    assign o_valid      = (r_cnt != '0);
    assign w_last       = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign w_take_out   = o_valid && !i_stall;
    // batch can take a new result when empty or when its last char leaves now
    assign w_batch_free = !o_valid || (w_take_out && w_last);
    assign w_enc_fire   = r_in_valid && w_batch_free;
    assign o_stall      = r_in_valid && !w_enc_fire;
    assign w_take_in    = i_valid && !o_stall;

    assign o_code_char  = r_chars[r_idx];
    assign o_final_char = r_fin && w_last;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take_in) begin
            r_in_valid <= 1'b1;
        end else if (w_enc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_in_byte <= i_text_byte;
            r_in_fin  <= i_final_byte;
        end
    end

    // coder state advances once per encoded item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_odd       <= 1'b0;
        end else if (w_enc_fire) begin
            r_pend_bits <= w_res.nxt_bits;
            r_pend_cnt  <= w_res.nxt_cnt;
            r_odd       <= w_res.nxt_odd;
        end
    end

    // result batch: load wins over drain of the last char
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (w_enc_fire && (w_res.n != '0)) begin
            r_cnt <= w_res.n;
            r_idx <= '0;
        end else if (w_take_out) begin
            if (w_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enc_fire && (w_res.n != '0)) begin
            r_chars <= w_res.chars;
            r_fin   <= w_res.fin;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_idx_in_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, r_idx} < r_cnt) && (r_cnt <= 3'd4))
        else $error("batch index outside batch");

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= 3'd5)
        else $error("pending count above five");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_enc_fire && r_in_fin |=> (r_pend_cnt == '0) && !r_odd)
        else $error("state not cleared after final byte");

    a_final_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_enc_fire && r_in_fin |-> (w_res.n != '0))
        else $error("final byte produced no character");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && o_valid)
        else $error("input stalled with a free stage");

endmodule

/* src/pcte_code.sv */
// ----------------------------------------------------------------------------
// pcte_code
// Prefix code lookup: one text byte to a code word and its length.
// ----------------------------------------------------------------------------
module pcte_code (
    input  logic [7:0]      i_byte,
    output pcte_pkg::t_code o_code
);
    import pcte_pkg::*;

    logic [7:0] w_low;
    logic [7:0] w_up;
    logic [7:0] w_dig;

    assign w_low = i_byte - 8'h61;   // 'a' -> 0
    assign w_up  = i_byte - 8'h2A;   // 'D' -> 26
    assign w_dig = i_byte - 8'h32;   // '2' -> 0

    always_comb begin
        o_code.len  = 4'd8;
        o_code.bits = 12'h0C0;
        if (i_byte == 8'h20) begin
            o_code = '{bits: 12'h000, len: 4'd2};
        end else if (i_byte == 8'h30) begin
            o_code = '{bits: 12'h004, len: 4'd4};
        end else if (i_byte == 8'h31) begin
            o_code = '{bits: 12'h005, len: 4'd4};
        end else if (i_byte >= 8'h32 && i_byte <= 8'h39) begin
            o_code = '{bits: {6'd0, 3'b011, w_dig[2:0]}, len: 4'd6};
        end else if (i_byte == 8'h41) begin
            o_code = '{bits: 12'h008, len: 4'd4};
        end else if (i_byte == 8'h43) begin
            o_code = '{bits: 12'h009, len: 4'd4};
        end else if (i_byte == 8'h2E) begin
            o_code = '{bits: 12'h00A, len: 4'd4};
        end else if (i_byte >= 8'h61 && i_byte <= 8'h7A) begin
            o_code.bits = {4'd0, 2'b11, w_low[5:0]};
        end else if (i_byte >= 8'h44 && i_byte <= 8'h5A) begin
            o_code.bits = {4'd0, 2'b11, w_up[5:0]};
        end else begin
            // 'B', DEL and frequent punctuation, else escape with the raw byte
            case (i_byte)
                8'h42:   o_code.bits = {4'd0, 2'b11, 6'd49};
                8'h21:   o_code.bits = {4'd0, 2'b11, 6'd50};
                8'h22:   o_code.bits = {4'd0, 2'b11, 6'd51};
                8'h5F:   o_code.bits = {4'd0, 2'b11, 6'd52};
                8'h23:   o_code.bits = {4'd0, 2'b11, 6'd53};
                8'h2B:   o_code.bits = {4'd0, 2'b11, 6'd54};
                8'h2D:   o_code.bits = {4'd0, 2'b11, 6'd55};
                8'h3D:   o_code.bits = {4'd0, 2'b11, 6'd56};
                8'h2A:   o_code.bits = {4'd0, 2'b11, 6'd57};
                8'h27:   o_code.bits = {4'd0, 2'b11, 6'd58};
                8'h26:   o_code.bits = {4'd0, 2'b11, 6'd59};
                8'h2F:   o_code.bits = {4'd0, 2'b11, 6'd60};
                8'h7F:   o_code.bits = {4'd0, 2'b11, 6'd61};
                8'h3C:   o_code.bits = {4'd0, 2'b11, 6'd62};
                8'h3E:   o_code.bits = {4'd0, 2'b11, 6'd63};
                default: o_code = '{bits: {4'b1011, i_byte}, len: 4'd12};
            endcase
        end
    end

endmodule

/* src/pcte_pack.sv */
// ----------------------------------------------------------------------------
// pcte_pack
// Appends a code word to the pending bits, cuts 6-bit symbols MSB first,
// pads on the final byte and maps symbols to readable characters.
// ----------------------------------------------------------------------------
module pcte_pack (
    input  pcte_pkg::t_code               i_code,
    input  logic [pcte_pkg::PEND_W-1:0]   i_pend_bits,
    input  logic [pcte_pkg::CNT_W-1:0]    i_pend_cnt,
    input  logic                          i_odd,
    input  logic                          i_fin,
    output pcte_pkg::t_pack_res           o_res
);
    import pcte_pkg::*;

    localparam int ACC_W = PEND_W + CODE_W;

    function automatic logic [CHAR_W-1:0] readable(input logic [SYM_W-1:0] s);
        logic [CHAR_W-1:0] r;
        r = {1'b0, s};
        if (s < 6'd26)      return r + 7'd97;
        else if (s < 6'd52) return r + 7'd39;
        else if (s < 6'd62) return r - 7'd4;
        else if (s == 6'd62) return 7'h5F;
        else                 return 7'h23;
    endfunction

    logic [ACC_W-1:0]  w_acc;
    logic [4:0]        w_total;
    logic [ACC_W-1:0]  w_sh0;
    logic [ACC_W-1:0]  w_sh1;
    logic [1:0]        w_nsym;
    logic [4:0]        w_rem5;
    logic [CNT_W-1:0]  w_rem;
    logic [PEND_W-1:0] w_rem_bits;
    logic [SYM_W-1:0]  w_pad_sym;
    logic              w_has_pad;
    logic              w_odd_after;
    logic [NOUT_W-1:0] w_slot;

    assign w_acc   = ({{CODE_W{1'b0}}, i_pend_bits} << i_code.len)
                   | {{PEND_W{1'b0}}, i_code.bits};
    assign w_total = {2'b00, i_pend_cnt} + {1'b0, i_code.len};
    assign w_sh0   = w_acc >> (w_total - 5'd6);
    assign w_sh1   = w_acc >> (w_total - 5'd12);

    always_comb begin
        if (w_total >= 5'd12) begin
            w_nsym = 2'd2;
            w_rem5 = w_total - 5'd12;
        end else if (w_total >= 5'd6) begin
            w_nsym = 2'd1;
            w_rem5 = w_total - 5'd6;
        end else begin
            w_nsym = 2'd0;
            w_rem5 = w_total;
        end
    end

    assign w_rem       = w_rem5[CNT_W-1:0];
    assign w_rem_bits  = w_acc[PEND_W-1:0] & ((5'd1 << w_rem) - 5'd1);
    assign w_pad_sym   = 6'({1'b0, w_rem_bits} << (3'd6 - w_rem));
    assign w_has_pad   = i_fin && (w_rem != '0);
    assign w_odd_after = i_odd ^ w_nsym[0] ^ w_has_pad;

    always_comb begin
        o_res.chars    = {MAX_OUT{CHAR_ZERO_SYM}};
        o_res.chars[0] = readable(w_sh0[SYM_W-1:0]);
        o_res.chars[1] = readable(w_sh1[SYM_W-1:0]);
        w_slot = {1'b0, w_nsym};
        if (w_has_pad) begin
            o_res.chars[w_slot[1:0]] = readable(w_pad_sym);
            w_slot = w_slot + 3'd1;
        end
        if (i_fin && w_odd_after) begin
            o_res.chars[w_slot[1:0]] = CHAR_ZERO_SYM;
            w_slot = w_slot + 3'd1;
        end
        o_res.n   = w_slot;
        o_res.fin = i_fin;
        if (i_fin) begin
            o_res.nxt_bits = '0;
            o_res.nxt_cnt  = '0;
            o_res.nxt_odd  = 1'b0;
        end else begin
            o_res.nxt_bits = w_rem_bits;
            o_res.nxt_cnt  = w_rem;
            o_res.nxt_odd  = w_odd_after;
        end
    end

endmodule
